### hw/rtl/mte_pkg.sv
// Shared constants, types and byte-class functions for the mention token extractor.
// No dependencies; every other file in this folder imports it.
package mte_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int HANDLE_SPAN_DEF = 32;

   localparam int CHAR_W     = 8;
   localparam int LIMIT_W    = 5;
   localparam int INDEX_W    = 4;
   localparam int SUFFIX_W   = 2;
   localparam int COUNT_W    = 5;
   localparam int APB_DATA_W = 32;
   localparam int APB_ADDR_W = 3;
   localparam int REG_IDX_W  = APB_ADDR_W - 2;

   localparam logic [LIMIT_W-1:0]   LIMIT_RESET       = 5'd16;
   localparam logic [REG_IDX_W-1:0] REG_MENTION_LIMIT = 1'b0;

   localparam logic [CHAR_W-1:0] CH_AT        = 8'h40;
   localparam logic [CHAR_W-1:0] CH_BANG      = 8'h21;
   localparam logic [CHAR_W-1:0] CH_QUERY     = 8'h3F;
   localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [CHAR_W-1:0] CH_DASH      = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_DOT       = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_PLUS      = 8'h2B;

   localparam logic [SUFFIX_W-1:0] SFX_PLAIN     = 2'd0;
   localparam logic [SUFFIX_W-1:0] SFX_INTERRUPT = 2'd1;
   localparam logic [SUFFIX_W-1:0] SFX_QUERY     = 2'd2;

   localparam logic KIND_HANDLE  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef logic [CHAR_W-1:0] char_type;

   // Broadcast from the controller to every cell of the row
   typedef struct packed {
      logic     cmp_en;
      logic     cmp_start;
      logic     wr_en;
      char_type cmp_byte;
      char_type wr_byte;
   } cell_ctl_type;

   function automatic logic is_alnum_byte(input char_type c);
      return ((c >= 8'h30) && (c <= 8'h39)) ||
             ((c >= 8'h61) && (c <= 8'h7A)) ||
             ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_handle_byte(input char_type c);
      return is_alnum_byte(c) || (c == CH_UNDERSCORE) || (c == CH_DASH);
   endfunction

   function automatic logic is_email_byte(input char_type c);
      return is_alnum_byte(c) || (c == CH_DOT) || (c == CH_UNDERSCORE) ||
             (c == CH_DASH) || (c == CH_PLUS);
   endfunction

   function automatic logic [SUFFIX_W-1:0] suffix_of(input char_type c);
      logic [SUFFIX_W-1:0] s;
      s = SFX_PLAIN;
      if (c == CH_BANG) begin
         s = SFX_INTERRUPT;
      end else if (c == CH_QUERY) begin
         s = SFX_QUERY;
      end
      return s;
   endfunction

endpackage

### hw/rtl/mte_if.sv
// Valid/ready channel interfaces for the byte input and the record output.
// Depends on mte_pkg for field widths.
interface mte_req_if import mte_pkg::*; ();
   logic     valid;
   logic     ready;
   char_type char_byte;
   logic     message_end;

   modport source (output valid, char_byte, message_end, input ready);
   modport sink   (input valid, char_byte, message_end, output ready);
endinterface

interface mte_rsp_if import mte_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                record_kind;
   char_type            handle_char;
   logic [INDEX_W-1:0]  mention_index;
   logic [SUFFIX_W-1:0] suffix_kind;
   logic                handle_end;
   logic [COUNT_W-1:0]  mention_count;
   logic                last_result;

   modport source (output valid, record_kind, handle_char, mention_index, suffix_kind,
                   handle_end, mention_count, last_result, input ready);
   modport sink   (input valid, record_kind, handle_char, mention_index, suffix_kind,
                   handle_end, mention_count, last_result, output ready);
endinterface

### hw/rtl/mention_token_extractor_core.sv
// Mention token extractor: top level with scan control, candidate buffer, record output
// and the row of found-handle cells. Depends on mte_pkg, mte_if, mte_csr and mte_cell.
//
// Takes one message byte per cycle while no word is being formed, and reports each new
// @handle as a burst of handle byte words, then a summary word on the last byte of the
// message. A byte that yields no word never holds the input. A byte that completes a new
// handle holds the input while the handle is streamed out of the candidate buffer and
// copied into its cell of the row, one byte per word; the summary word holds it too. The
// output register lets a word wait for the sink while later bytes are scanned. Duplicate
// checks need no separate pass: every cell compares its stored handle with each candidate
// byte as it arrives and the hit travels down the row. No clearing is needed after reset.
module mention_token_extractor_core import mte_pkg::*; #(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int HANDLE_SPAN = HANDLE_SPAN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   mte_req_if.sink               req_if,
   mte_rsp_if.source             rsp_if,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int POS_W  = $clog2(HANDLE_SPAN);
   localparam int LEN_W  = $clog2(HANDLE_SPAN + 1);
   localparam int SLOT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W  = (LIMIT_W > CNT_W) ? LIMIT_W : CNT_W;

   typedef enum logic [1:0] {MODE_IDLE, MODE_AT, MODE_COLLECT, MODE_ESCAPE} mode_type;
   typedef enum logic [1:0] {PH_IDLE, PH_EMIT, PH_SUM} phase_type;

   mode_type            mode_ff, mode_in;
   phase_type           phase_ff, phase_in;
   char_type            prev_ff, prev_in;
   logic                has_prev_ff, has_prev_in;
   logic [LEN_W-1:0]    cand_len_ff, cand_len_in;
   logic [CNT_W-1:0]    found_ff, found_in;
   char_type            cand_ff [HANDLE_SPAN];
   char_type            cand_in [HANDLE_SPAN];
   logic [SLOT_W-1:0]   pend_slot_ff, pend_slot_in;
   logic [LEN_W-1:0]    pend_len_ff, pend_len_in;
   logic [SUFFIX_W-1:0] sfx_ff, sfx_in;
   logic                sum_pend_ff, sum_pend_in;
   logic [COUNT_W-1:0]  sum_count_ff, sum_count_in;
   logic [POS_W-1:0]    k_ff, k_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff, rsp_kind_in;
   char_type            rsp_char_ff, rsp_char_in;
   logic [INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [SUFFIX_W-1:0] rsp_suffix_ff, rsp_suffix_in;
   logic                rsp_end_ff, rsp_end_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [LIMIT_W-1:0]   mention_limit;
   logic [CMP_W-1:0]     eff_limit;
   logic                 accept;
   char_type             in_byte;
   logic                 handle_c;
   logic                 cmp_en;
   logic [LEN_W-1:0]     fin_len;
   logic                 out_free;
   logic                 sweep_step;
   logic                 sweep_last;
   logic                 is_new;
   logic                 emit_go;
   cell_ctl_type         cell_ctl;
   logic [LEN_W-1:0]     len_bus;
   logic [MAX_ENTRIES:0] hit_chain;

   mte_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .mention_limit (mention_limit)
   );

   assign eff_limit = (CMP_W'(mention_limit) > CMP_W'(MAX_ENTRIES)) ?
                      CMP_W'(MAX_ENTRIES) : CMP_W'(mention_limit);

   assign req_if.ready = (phase_ff == PH_IDLE);
   assign accept       = req_if.valid && (phase_ff == PH_IDLE);
   assign in_byte      = req_if.char_byte;
   assign handle_c     = is_handle_byte(in_byte);

   assign cmp_en = accept && handle_c &&
                   ((mode_ff == MODE_AT) ||
                    ((mode_ff == MODE_COLLECT) && (cand_len_ff < LEN_W'(HANDLE_SPAN))));
   assign fin_len = cand_len_ff + LEN_W'(cmp_en);

   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign sweep_step = (phase_ff == PH_EMIT) && out_free;
   assign sweep_last = ((LEN_W'(k_ff) + LEN_W'(1)) == pend_len_ff);

   assign is_new = (fin_len != '0) && (fin_len < LEN_W'(HANDLE_SPAN)) &&
                   !hit_chain[MAX_ENTRIES] && (found_ff < CNT_W'(MAX_ENTRIES));

   always_comb begin
      cell_ctl.cmp_en    = cmp_en;
      cell_ctl.cmp_start = (mode_ff == MODE_AT);
      cell_ctl.cmp_byte  = in_byte;
      cell_ctl.wr_en     = sweep_step;
      cell_ctl.wr_byte   = cand_ff[0];
   end

   assign len_bus = (phase_ff == PH_EMIT) ? pend_len_ff : fin_len;

   assign hit_chain[0] = 1'b0;

   for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      mte_cell #(
         .CELL_ID     (gi),
         .MAX_ENTRIES (MAX_ENTRIES),
         .HANDLE_SPAN (HANDLE_SPAN)
      ) u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .rd_pos      (cand_len_in[POS_W-1:0]),
         .wr_pos      (k_ff),
         .wr_slot     (pend_slot_ff),
         .len_bus     (len_bus),
         .found_count (found_ff),
         .hit_in      (hit_chain[gi]),
         .hit_out     (hit_chain[gi+1])
      );
   end

   always_comb begin
      mode_in      = mode_ff;
      phase_in     = phase_ff;
      prev_in      = prev_ff;
      has_prev_in  = has_prev_ff;
      cand_len_in  = cand_len_ff;
      found_in     = found_ff;
      cand_in      = cand_ff;
      pend_slot_in = pend_slot_ff;
      pend_len_in  = pend_len_ff;
      sfx_in       = sfx_ff;
      sum_pend_in  = sum_pend_ff;
      sum_count_in = sum_count_ff;
      k_in         = k_ff;
      emit_go      = 1'b0;

      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_suffix_in = rsp_suffix_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (phase_ff)
         PH_IDLE: begin
            if (accept) begin
               unique case (mode_ff)
                  MODE_ESCAPE: begin
                     emit_go = 1'b1;
                     sfx_in  = suffix_of(in_byte);
                     mode_in = MODE_IDLE;
                  end
                  MODE_COLLECT: begin
                     if (handle_c) begin
                        if (cmp_en) begin
                           cand_in[cand_len_ff[POS_W-1:0]] = in_byte;
                           cand_len_in = fin_len;
                        end
                     end else begin
                        mode_in     = MODE_IDLE;
                        cand_len_in = '0;
                        if (is_new) begin
                           found_in     = found_ff + CNT_W'(1);
                           pend_slot_in = SLOT_W'(found_ff);
                           pend_len_in  = fin_len;
                           // A backslash defers the tag to the next byte
                           if (in_byte == CH_BACKSLASH) begin
                              mode_in = MODE_ESCAPE;
                           end else begin
                              emit_go = 1'b1;
                              sfx_in  = suffix_of(in_byte);
                           end
                        end
                     end
                  end
                  MODE_AT: begin
                     if (handle_c) begin
                        cand_in[0]  = in_byte;
                        cand_len_in = fin_len;
                        mode_in     = MODE_COLLECT;
                     end else begin
                        mode_in = MODE_IDLE;
                     end
                  end
                  MODE_IDLE: begin
                  end
               endcase

               if ((mode_in == MODE_IDLE) && (in_byte == CH_AT) &&
                   (CMP_W'(found_in) < eff_limit) &&
                   !(has_prev_ff && is_email_byte(prev_ff))) begin
                  mode_in = MODE_AT;
               end

               prev_in     = in_byte;
               has_prev_in = 1'b1;

               if (req_if.message_end) begin
                  if (mode_in == MODE_COLLECT) begin
                     if (is_new) begin
                        found_in     = found_ff + CNT_W'(1);
                        pend_slot_in = SLOT_W'(found_ff);
                        pend_len_in  = fin_len;
                        emit_go      = 1'b1;
                        sfx_in       = SFX_PLAIN;
                     end
                  end else if (mode_in == MODE_ESCAPE) begin
                     emit_go = 1'b1;
                     sfx_in  = SFX_PLAIN;
                  end
                  sum_pend_in  = 1'b1;
                  sum_count_in = COUNT_W'(found_in);
                  mode_in      = MODE_IDLE;
                  prev_in      = '0;
                  has_prev_in  = 1'b0;
                  cand_len_in  = '0;
                  found_in     = '0;
               end else begin
                  sum_pend_in = 1'b0;
               end

               k_in = '0;
               if (emit_go) begin
                  phase_in = PH_EMIT;
               end else if (req_if.message_end) begin
                  phase_in = PH_SUM;
               end
            end
         end
         PH_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_HANDLE;
               rsp_char_in   = cand_ff[0];
               rsp_index_in  = INDEX_W'(pend_slot_ff);
               rsp_suffix_in = sfx_ff;
               rsp_end_in    = sweep_last;
               rsp_count_in  = '0;
               rsp_last_in   = sweep_last && !sum_pend_ff;
               // Rotate the buffer so the next handle byte sits at the head
               for (int i = 0; i < HANDLE_SPAN - 1; i++) begin
                  cand_in[i] = cand_ff[i+1];
               end
               cand_in[HANDLE_SPAN-1] = cand_ff[0];
               k_in = k_ff + POS_W'(1);
               if (sweep_last) begin
                  phase_in = sum_pend_ff ? PH_SUM : PH_IDLE;
               end
            end
         end
         PH_SUM: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_SUMMARY;
               rsp_char_in   = '0;
               rsp_index_in  = '0;
               rsp_suffix_in = SFX_PLAIN;
               rsp_end_in    = 1'b0;
               rsp_count_in  = sum_count_ff;
               rsp_last_in   = 1'b1;
               phase_in      = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         phase_ff     <= PH_IDLE;
         prev_ff      <= '0;
         has_prev_ff  <= 1'b0;
         cand_len_ff  <= '0;
         found_ff     <= '0;
         sum_pend_ff  <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         phase_ff      <= phase_in;
         prev_ff       <= prev_in;
         has_prev_ff   <= has_prev_in;
         cand_len_ff   <= cand_len_in;
         found_ff      <= found_in;
         cand_ff       <= cand_in;
         pend_slot_ff  <= pend_slot_in;
         pend_len_ff   <= pend_len_in;
         sfx_ff        <= sfx_in;
         sum_pend_ff   <= sum_pend_in;
         sum_count_ff  <= sum_count_in;
         k_ff          <= k_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_kind_ff   <= rsp_kind_in;
         rsp_char_ff   <= rsp_char_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_suffix_ff <= rsp_suffix_in;
         rsp_end_ff    <= rsp_end_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.record_kind   = rsp_kind_ff;
   assign rsp_if.handle_char   = rsp_char_ff;
   assign rsp_if.mention_index = rsp_index_ff;
   assign rsp_if.suffix_kind   = rsp_suffix_ff;
   assign rsp_if.handle_end    = rsp_end_ff;
   assign rsp_if.mention_count = rsp_count_ff;
   assign rsp_if.last_result   = rsp_last_ff;

endmodule

### hw/rtl/mte_csr.sv
// APB-style register port holding the mention limit.
// Depends on mte_pkg.
module mte_csr import mte_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [LIMIT_W-1:0]    mention_limit
);

   logic [LIMIT_W-1:0] limit_ff;
   logic [LIMIT_W-1:0] limit_in;
   logic               hit_reg;

   assign pready  = 1'b1;
   assign hit_reg = (paddr[APB_ADDR_W-1:2] == REG_MENTION_LIMIT);

   always_comb begin
      limit_in = limit_ff;
      if (psel && penable && pwrite && pready && hit_reg) begin
         limit_in = pwdata[LIMIT_W-1:0];
      end
   end

   assign prdata        = hit_reg ? APB_DATA_W'(limit_ff) : '0;
   assign mention_limit = limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

endmodule

### hw/rtl/mte_cell.sv
// One entry of the found-handle row: stored bytes, length and a running prefix match
// against the candidate being collected. Depends on mte_pkg.
module mte_cell import mte_pkg::*; #(
   parameter int  CELL_ID     = 0,
   parameter int  MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int  HANDLE_SPAN = HANDLE_SPAN_DEF,
   localparam int POS_W       = $clog2(HANDLE_SPAN),
   localparam int LEN_W       = $clog2(HANDLE_SPAN + 1),
   localparam int SLOT_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
   input  logic              clock,
   input  cell_ctl_type      ctl,
   input  logic [POS_W-1:0]  rd_pos,
   input  logic [POS_W-1:0]  wr_pos,
   input  logic [SLOT_W-1:0] wr_slot,
   input  logic [LEN_W-1:0]  len_bus,
   input  logic [CNT_W-1:0]  found_count,
   input  logic              hit_in,
   output logic              hit_out
);

   char_type         store_mem [HANDLE_SPAN];
   char_type         rd_ff;
   logic             match_ff;
   logic [LEN_W-1:0] len_ff;
   logic             sel;
   logic             eq;
   logic             match_now;
   logic             live;

   assign sel  = (wr_slot == SLOT_W'(CELL_ID));
   assign eq   = (rd_ff == ctl.cmp_byte);
   assign live = (CNT_W'(CELL_ID) < found_count);

   // Fold in the byte arriving this cycle so an end-of-message finish sees it
   assign match_now = ctl.cmp_en ? ((ctl.cmp_start || match_ff) && eq) : match_ff;

   assign hit_out = hit_in || (live && (len_ff == len_bus) && match_now);

   always_ff @(posedge clock) begin
      if (ctl.wr_en && sel) begin
         store_mem[wr_pos] <= ctl.wr_byte;
         if (wr_pos == '0) begin
            len_ff <= len_bus;
         end
      end
      // Read ahead at the position of the next candidate byte
      rd_ff <= store_mem[rd_pos];
      if (ctl.cmp_en) begin
         match_ff <= match_now;
      end
   end

endmodule
